// ===== rtl/core/bale_pkg.sv =====
package bale_pkg;

    // input beat packing: cmd, position, item_value
    localparam int CMD_W  = 3;
    localparam int POS_W  = 6;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;
    localparam int IN_W   = ((CMD_W + POS_W + VAL_W + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND   = 3'd0,
        CMD_REM_VAL  = 3'd1,
        CMD_REM_AT   = 3'd2,
        CMD_WRITE    = 3'd3,
        CMD_READ     = 3'd4,
        CMD_CONTAINS = 3'd5,
        CMD_CLEAR    = 3'd6
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK   = 2'd0,
        STAT_MISS = 2'd1,
        STAT_FULL = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RDAT,
        S_SCAN,
        S_SHIFT,
        S_FIN
    } state_t;

    // finished command handed to the output stage
    typedef struct packed {
        logic             valid;
        status_t          status;
        logic [VAL_W-1:0] read_value;
    } result_t;

endpackage

// ===== rtl/core/bale_ram.sv =====
module bale_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/bale_ctrl.sv =====
module bale_ctrl #(
    parameter int DEPTH = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [bale_pkg::CMD_W-1:0]          in_cmd,
    input  logic [bale_pkg::POS_W-1:0]          in_pos,
    input  logic [bale_pkg::VAL_W-1:0]          in_val,
    output bale_pkg::result_t                   res,
    input  logic                                res_ready,
    output logic [$clog2(DEPTH+1)-1:0]          count
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = (CNT_W > bale_pkg::POS_W) ? CNT_W : bale_pkg::POS_W;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    bale_pkg::state_t  state_reg, state_next;
    bale_pkg::cmd_t    cmd_reg, cmd_next;
    bale_pkg::status_t status_reg, status_next;

    logic [bale_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [bale_pkg::VAL_W-1:0] val_reg, val_next;
    logic [bale_pkg::VAL_W-1:0] rv_reg, rv_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [CNT_W-1:0]           rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]           pipe_idx_reg, pipe_idx_next;
    logic                       pipe_vld_reg, pipe_vld_next;

    logic                       ram_wr_en, ram_rd_en;
    logic [ADDR_W-1:0]          ram_wr_addr, ram_rd_addr;
    logic [bale_pkg::VAL_W-1:0] ram_wr_data, ram_rd_data;

    logic [CMP_W-1:0] pos_ext, count_ext;
    logic             pos_ok;
    logic             issue;
    logic             hit;
    logic [CNT_W-1:0] shift_dst;
    logic [CNT_W-1:0] pos_plus;

    bale_ram #(
        .WIDTH (bale_pkg::VAL_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign pos_ext   = CMP_W'(pos_reg);
    assign count_ext = CMP_W'(count_reg);
    assign pos_ok    = pos_ext < count_ext;
    assign pos_plus  = CNT_W'(pos_ext + CMP_W'(1));
    assign issue     = rd_idx_reg < count_reg;
    assign hit       = pipe_vld_reg && (ram_rd_data == val_reg);
    assign shift_dst = pipe_idx_reg - CNT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= bale_pkg::S_IDLE;
            count_reg    <= '0;
            pipe_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            pipe_vld_reg <= pipe_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        status_reg   <= status_next;
        pos_reg      <= pos_next;
        val_reg      <= val_next;
        rv_reg       <= rv_next;
        rd_idx_reg   <= rd_idx_next;
        pipe_idx_reg <= pipe_idx_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        status_next    = status_reg;
        pos_next       = pos_reg;
        val_next       = val_reg;
        rv_next        = rv_reg;
        count_next     = count_reg;
        rd_idx_next    = rd_idx_reg;
        pipe_idx_next  = pipe_idx_reg;
        pipe_vld_next  = pipe_vld_reg;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = '0;
        ram_wr_data    = ram_rd_data;
        ram_rd_en      = 1'b0;
        ram_rd_addr    = '0;
        in_ready       = 1'b0;
        res.valid      = 1'b0;
        res.status     = status_reg;
        res.read_value = rv_reg;

        unique case (state_reg)
            bale_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd_next   = bale_pkg::cmd_t'(in_cmd);
                    pos_next   = in_pos;
                    val_next   = in_val;
                    state_next = bale_pkg::S_EXEC;
                end
            end

            bale_pkg::S_EXEC:
            begin
                status_next   = bale_pkg::STAT_MISS;
                rv_next       = '0;
                rd_idx_next   = '0;
                pipe_vld_next = 1'b0;
                state_next    = bale_pkg::S_FIN;
                case (cmd_reg)
                    bale_pkg::CMD_APPEND:
                    begin
                        if (count_reg == FULL_CNT)
                        begin
                            status_next = bale_pkg::STAT_FULL;
                        end
                        else
                        begin
                            ram_wr_en   = 1'b1;
                            ram_wr_addr = count_reg[ADDR_W-1:0];
                            ram_wr_data = val_reg;
                            count_next  = count_reg + CNT_W'(1);
                            status_next = bale_pkg::STAT_OK;
                        end
                    end
                    bale_pkg::CMD_REM_VAL, bale_pkg::CMD_CONTAINS:
                    begin
                        state_next = bale_pkg::S_SCAN;
                    end
                    bale_pkg::CMD_REM_AT, bale_pkg::CMD_READ:
                    begin
                        if (pos_ok)
                        begin
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = pos_ext[ADDR_W-1:0];
                            rd_idx_next = pos_plus;
                            state_next  = bale_pkg::S_RDAT;
                        end
                    end
                    bale_pkg::CMD_WRITE:
                    begin
                        if (pos_ok)
                        begin
                            ram_wr_en   = 1'b1;
                            ram_wr_addr = pos_ext[ADDR_W-1:0];
                            ram_wr_data = val_reg;
                            status_next = bale_pkg::STAT_OK;
                        end
                    end
                    bale_pkg::CMD_CLEAR:
                    begin
                        count_next  = '0;
                        status_next = bale_pkg::STAT_OK;
                    end
                    default:
                    begin
                        status_next = bale_pkg::STAT_MISS;
                    end
                endcase
            end

            bale_pkg::S_RDAT:
            begin
                rv_next     = ram_rd_data;
                status_next = bale_pkg::STAT_OK;
                if (cmd_reg == bale_pkg::CMD_REM_AT)
                begin
                    state_next = bale_pkg::S_SHIFT;
                end
                else
                begin
                    state_next = bale_pkg::S_FIN;
                end
            end

            bale_pkg::S_SCAN:
            begin
                // one read issued per cycle, compare on the returning word
                if (hit)
                begin
                    status_next = bale_pkg::STAT_OK;
                    if (cmd_reg == bale_pkg::CMD_REM_VAL)
                    begin
                        rv_next       = ram_rd_data;
                        rd_idx_next   = pipe_idx_reg + CNT_W'(1);
                        pipe_vld_next = 1'b0;
                        state_next    = bale_pkg::S_SHIFT;
                    end
                    else
                    begin
                        state_next = bale_pkg::S_FIN;
                    end
                end
                else if (!issue && !pipe_vld_reg)
                begin
                    state_next = bale_pkg::S_FIN;
                end
                else
                begin
                    ram_rd_en     = issue;
                    ram_rd_addr   = rd_idx_reg[ADDR_W-1:0];
                    pipe_vld_next = issue;
                    pipe_idx_next = rd_idx_reg;
                    rd_idx_next   = rd_idx_reg + CNT_W'(issue);
                end
            end

            bale_pkg::S_SHIFT:
            begin
                // read entry i while entry i-1 is written one slot down
                if (pipe_vld_reg)
                begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = shift_dst[ADDR_W-1:0];
                    ram_wr_data = ram_rd_data;
                end
                if (!issue && !pipe_vld_reg)
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = bale_pkg::S_FIN;
                end
                else
                begin
                    ram_rd_en     = issue;
                    ram_rd_addr   = rd_idx_reg[ADDR_W-1:0];
                    pipe_vld_next = issue;
                    pipe_idx_next = rd_idx_reg;
                    rd_idx_next   = rd_idx_reg + CNT_W'(issue);
                end
            end

            bale_pkg::S_FIN:
            begin
                res.valid = 1'b1;
                if (res_ready)
                begin
                    state_next = bale_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = bale_pkg::S_IDLE;
            end
        endcase
    end

    assign count = count_reg;

endmodule

// ===== rtl/core/bounded_array_list_engine.sv =====
// command flow: append, write, clear, index misses and unused code 7 finish in the execute state, read
//   fetches the word first, contains and remove-value scan entries from index 0 until a hit or the end,
//   remove-at and remove-value then move the later entries down one slot
// throughput: one command at a time, the next beat is taken the cycle after the result
//   moves to the output register
// reset: rst_n clears the entry count, the sequencer and the output valid flag, stored words stay undefined
module bounded_array_list_engine #(
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     s_tvalid,
    output logic                     s_tready,
    // cmd[2:0], position[8:3], item_value[40:9], zero pad above
    input  logic [bale_pkg::IN_W-1:0] s_tdata,

    output logic                     m_tvalid,
    input  logic                     m_tready,
    // status[1:0], read_value[33:2], entry_count, is_empty, zero pad above
    output logic [((bale_pkg::STAT_W + bale_pkg::VAL_W + $clog2(DEPTH+1) + 1 + 7) / 8) * 8 - 1:0]
                                     m_tdata
);

    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int RES_W  = bale_pkg::STAT_W + bale_pkg::VAL_W + CNT_W + 1;
    localparam int OUT_W  = ((RES_W + 7) / 8) * 8;
    localparam int POS_LO = bale_pkg::CMD_W;
    localparam int VAL_LO = bale_pkg::CMD_W + bale_pkg::POS_W;

    bale_pkg::result_t res;
    logic              res_ready;
    logic [CNT_W-1:0]  count;

    logic              out_valid_reg;
    logic [OUT_W-1:0]  out_data_reg;
    logic [RES_W-1:0]  res_packed;

    // sequencer with the entry memory inside
    bale_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (s_tdata[bale_pkg::CMD_W-1:0]),
        .in_pos    (s_tdata[POS_LO +: bale_pkg::POS_W]),
        .in_val    (s_tdata[VAL_LO +: bale_pkg::VAL_W]),
        .res       (res),
        .res_ready (res_ready),
        .count     (count)
    );

    // output beat register, refilled in the cycle it drains
    assign res_ready  = !out_valid_reg || m_tready;
    assign res_packed = {(count == '0), count, res.read_value, res.status};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res.valid)
        begin
            out_data_reg <= OUT_W'(res_packed);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
